>>> sv/ecus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecus_pkg
// Shared types and constants for the unlock-guarded byte store.
// ----------------------------------------------------------------------------
package ecus_pkg;

  // Store geometry
  localparam int          STORE_DEPTH_DEF = 131072;
  localparam int          CELL_W          = 17;     // width of addr[18:2]
  localparam logic [7:0]  ERASED_BYTE     = 8'hFF;

  // Bus addresses of the unlock cells and the product-ID bytes
  localparam logic [23:0] BUS_BASE        = 24'h800000;
  localparam logic [23:0] UNLOCK_A_ADDR   = 24'h815554; // cell 5555
  localparam logic [23:0] UNLOCK_B_ADDR   = 24'h80AAA8; // cell 2AAA
  localparam logic [23:0] PID_MAKER_ADDR  = BUS_BASE;
  localparam logic [23:0] PID_DEVICE_ADDR = 24'h800004;

  // Unlock sequence words and commands
  localparam logic [15:0] UNLOCK_A_WORD   = 16'h00AA;
  localparam logic [15:0] UNLOCK_B_WORD   = 16'h0055;
  localparam logic [15:0] CMD_PROD_ID     = 16'h0090;
  localparam logic [15:0] CMD_WRITE_EN    = 16'h00A0;

  // Configuration register indexes and reset values
  localparam int          CFG_IDX_W       = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MAKER_CODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_CODE = 8'd1;
  localparam logic [7:0]  MAKER_CODE_RST  = 8'h1F;
  localparam logic [7:0]  DEVICE_CODE_RST = 8'hD5;

  typedef enum logic [1:0] {
    CMD_RD_WORD = 2'd0,
    CMD_RD_LONG = 2'd1,
    CMD_WR_WORD = 2'd2,
    CMD_WR_LONG = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_PROD_ID  = 2'd1,
    MODE_WRITE_EN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  // Decoded operation that travels down the pipeline with each item
  typedef struct packed {
    logic       rd;        // read: produces one result
    logic       wr;        // store byte_val into the cell
    logic       rd_long;   // long read: byte lands in bits 23:16
    logic       rd_zero;   // word read at a nonzero offset returns zero
    logic       pid;       // product-ID read: byte_val replaces store data
    logic [7:0] byte_val;  // write byte or product-ID byte
  } op_t;

endpackage

>>> sv/ecus_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecus_ctrl
// Unlock sequencer, access mode and ID registers; decodes each command.
// ----------------------------------------------------------------------------
module ecus_ctrl
  import ecus_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [1:0]           cmd,
  input  logic [23:0]          addr,
  input  logic [31:0]          data,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]           cfg_val,
  output op_t                  op
);

  phase_t      phase_r, phase_nxt;
  mode_t       mode_r, mode_nxt;
  logic [7:0]  maker_r, device_r;
  cmd_t        cmd_c;
  logic [23:0] waddr;
  logic [15:0] wword;
  logic        second_cell;
  logic        wr_skip;

  // Hold sequencer state and mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mode_r  <= MODE_NORMAL;
    end else begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Take configuration transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maker_r  <= MAKER_CODE_RST;
      device_r <= DEVICE_CODE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAKER_CODE:  maker_r  <= cfg_val;
        REG_DEVICE_CODE: device_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // Align long writes; a word write to offset two is dropped
  assign cmd_c       = cmd_t'(cmd);
  assign waddr       = (cmd_c == CMD_WR_LONG) ? {addr[23:2], 2'b00} : addr;
  assign wword       = data[15:0];
  assign second_cell = (waddr == UNLOCK_B_ADDR);
  assign wr_skip     = (cmd_c == CMD_WR_WORD) && (addr[1:0] == 2'd2);

  // Decode the command and advance the unlock sequence
  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    op        = '0;
    if (acc) begin
      case (cmd_c)
        CMD_RD_WORD, CMD_RD_LONG: begin
          op.rd      = 1'b1;
          op.rd_long = (cmd_c == CMD_RD_LONG);
          op.rd_zero = (cmd_c == CMD_RD_WORD) && (addr[1:0] != 2'b00);
          if (mode_r == MODE_PROD_ID) begin
            op.pid = 1'b1;
            if (addr == PID_MAKER_ADDR) begin
              op.byte_val = maker_r;
            end else if (addr == PID_DEVICE_ADDR) begin
              op.byte_val = device_r;
            end
          end
          // any read drops write-enable mode
          if (mode_r == MODE_WRITE_EN) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        default: begin
          if (!wr_skip) begin
            if (mode_r == MODE_WRITE_EN) begin
              op.wr       = 1'b1;
              op.byte_val = wword[7:0];
            end else if ((waddr == UNLOCK_A_ADDR) || second_cell) begin
              case (phase_r)
                PH_IDLE: begin
                  if (!second_cell && (wword == UNLOCK_A_WORD)) begin
                    phase_nxt = PH_ONE;
                  end
                end
                PH_ONE: begin
                  phase_nxt = (second_cell && (wword == UNLOCK_B_WORD)) ? PH_TWO : PH_IDLE;
                end
                PH_TWO: begin
                  if (!second_cell) begin
                    if (wword == CMD_PROD_ID) begin
                      mode_nxt = MODE_PROD_ID;
                    end else if (wword == CMD_WRITE_EN) begin
                      mode_nxt = MODE_WRITE_EN;
                    end else begin
                      mode_nxt = MODE_NORMAL;
                    end
                  end
                  phase_nxt = PH_IDLE;
                end
                default: begin
                  phase_nxt = PH_IDLE;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

endmodule

>>> sv/ecus_idx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecus_idx
// Two-stage cell index unit: bus cell number modulo the store depth,
// by reciprocal multiply, with the decoded operation carried alongside.
// ----------------------------------------------------------------------------
module ecus_idx
  import ecus_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [CELL_W-1:0]              in_cell,
  input  op_t                            in_op,
  output logic                           out_vld,
  output logic [$clog2(STORE_DEPTH)-1:0] out_idx,
  output op_t                            out_op
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int SH     = CELL_W + IDX_W;
  localparam int MUL_W  = CELL_W + 1;
  localparam int PROD_W = CELL_W + MUL_W;
  localparam int Q_W    = PROD_W - SH;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH);
  localparam logic [MUL_W-1:0]  RECIP_C = MUL_W'(RECIP);
  localparam logic [CELL_W-1:0] DEPTH_C = CELL_W'(STORE_DEPTH);

  logic                vld1_r, vld2_r;
  logic [CELL_W-1:0]   cell1_r;
  logic [PROD_W-1:0]   prod1_r;
  op_t                 op1_r, op2_r;
  logic [Q_W-1:0]      quot;
  logic [CELL_W-1:0]   rem;
  logic [IDX_W-1:0]    idx2_r;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  // Stage one: multiply by the reciprocal of the depth
  always_ff @(posedge clk) begin
    cell1_r <= in_cell;
    prod1_r <= PROD_W'(in_cell) * PROD_W'(RECIP_C);
    op1_r   <= in_op;
  end

  // Stage two: remainder from the quotient
  assign quot = prod1_r[PROD_W-1 -: Q_W];
  assign rem  = cell1_r - CELL_W'(CELL_W'(quot) * DEPTH_C);

  always_ff @(posedge clk) begin
    idx2_r <= rem[IDX_W-1:0];
    op2_r  <= op1_r;
  end

  assign out_vld = vld2_r;
  assign out_idx = idx2_r;
  assign out_op  = op2_r;

endmodule

>>> sv/ecus_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecus_mem
// Single-port byte store with a registered read and an erase sweep
// after reset that fills every cell with the erased value.
// ----------------------------------------------------------------------------
module ecus_mem
  import ecus_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic [$clog2(STORE_DEPTH)-1:0] in_idx,
  input  op_t                            in_op,
  output logic                           clr_busy,
  output logic                           rd_vld,
  output logic [7:0]                     rd_byte,
  output op_t                            rd_op
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  logic [7:0]       mem [STORE_DEPTH];
  logic             clr_act_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic             rd_vld_r;
  logic [7:0]       rd_byte_r;
  op_t              rd_op_r;

  // Sweep the store once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_act_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_IDX) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  // Write port: erase sweep or item write; read port registered
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[clr_cnt_r] <= ERASED_BYTE;
    end else if (in_vld && in_op.wr) begin
      mem[in_idx] <= in_op.byte_val;
    end
    if (in_vld && in_op.rd) begin
      rd_byte_r <= mem[in_idx];
    end
  end

  // Carry read results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= in_vld && in_op.rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_op_r <= in_op;
  end

  assign clr_busy = clr_act_r;
  assign rd_vld   = rd_vld_r;
  assign rd_byte  = rd_byte_r;
  assign rd_op    = rd_op_r;

endmodule

>>> sv/eeprom_command_unlock_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeprom_command_unlock_store
// Byte-wide store behind a 32-bit bus, guarded by a three-write unlock
// sequence that selects product-ID reads or write enable.
// ----------------------------------------------------------------------------
//  channel  ports                                      transfer when
//  -------  -----------------------------------------  -------------------
//  command  start, busy, in_cmd, in_addr, in_data      start && !busy
//  result   out_valid, out_read_data                   out_valid (1 cycle)
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
//  One command is taken every cycle while busy is low; a read's result passes
//  through the index multiply, remainder, memory read and output registers.
//  Writes give no result. The single memory port sets the one-per-cycle rate.
//  After reset busy stays high while the erase sweep
//  fills the store with FF; config transfers are taken throughout.
//  The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module eeprom_command_unlock_store
  import ecus_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic [23:0]          in_addr,
  input  logic [31:0]          in_data,
  output logic                 out_valid,
  output logic [31:0]          out_read_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int IDX_W = $clog2(STORE_DEPTH);

  logic             acc;
  logic             clr_busy;
  op_t              dec_op;
  logic             ix_vld;
  logic [IDX_W-1:0] ix_idx;
  op_t              ix_op;
  logic             rd_vld;
  logic [7:0]       rd_byte;
  op_t              rd_op;
  logic [7:0]       res_byte;
  logic [31:0]      res_word;
  logic             out_valid_r;
  logic [31:0]      out_read_data_r;

  assign busy      = clr_busy;
  assign cfg_ready = 1'b1;
  assign acc       = start && !clr_busy;

  // Decode and sequence
  ecus_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .cmd     (in_cmd),
    .addr    (in_addr),
    .data    (in_data),
    .cfg_wr  (cfg_valid && cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .op      (dec_op)
  );

  // Cell index
  ecus_idx #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_idx (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_cell (in_addr[18:2]),
    .in_op   (dec_op),
    .out_vld (ix_vld),
    .out_idx (ix_idx),
    .out_op  (ix_op)
  );

  // Byte store
  ecus_mem #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (ix_vld),
    .in_idx   (ix_idx),
    .in_op    (ix_op),
    .clr_busy (clr_busy),
    .rd_vld   (rd_vld),
    .rd_byte  (rd_byte),
    .rd_op    (rd_op)
  );

  // Place the byte on the bus lanes
  assign res_byte = rd_op.pid ? rd_op.byte_val : rd_byte;

  always_comb begin
    if (rd_op.rd_long) begin
      res_word = {8'h00, res_byte, 16'h0000};
    end else if (rd_op.rd_zero) begin
      res_word = '0;
    end else begin
      res_word = {24'h000000, res_byte};
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_read_data_r <= res_word;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

  // No result while the store is being erased
  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result during erase sweep");

  // A read yields a result
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_cmd[1]) |-> ##4 out_valid)
    else $error("read result missing");

  // A write yields no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd[1]) |-> ##4 !out_valid)
    else $error("result from a write");

  // Word read at a nonzero offset returns zero
  a_word_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_RD_WORD) && (in_addr[1:0] != 2'b00))
      |-> ##4 (out_read_data == 32'h0))
    else $error("nonzero word read at unaligned offset");

endmodule
